FILE: rtl/core/nva_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nva_pkg
// Shared constants, codes and controller/datapath interface types for the
// note voice allocator.
// ----------------------------------------------------------------------------
package nva_pkg;

    localparam int ENTITY_COUNT      = 16;
    localparam int VOICES_PER_ENTITY = 8;
    localparam int SLOT_COUNT        = ENTITY_COUNT * VOICES_PER_ENTITY;

    localparam int SLOT_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int ENT_IW  = (ENTITY_COUNT > 1) ? $clog2(ENTITY_COUNT) : 1;
    localparam int SUB_W   = (VOICES_PER_ENTITY > 1) ? $clog2(VOICES_PER_ENTITY) : 1;
    localparam int CNT_W   = $clog2(VOICES_PER_ENTITY + 1);
    localparam int VIC_W   = $clog2(VOICES_PER_ENTITY + 2);
    localparam int MLIVE_W = $clog2(SLOT_COUNT + 1);
    localparam int CMP_W   = ((MLIVE_W > 8) ? MLIVE_W : 8) + 2;

    localparam logic [7:0]  MULTI_LIMIT_RESET = 8'd16;
    localparam logic [31:0] NS_MASK  = 32'hC000_0000;
    localparam logic [31:0] NS_EXT_A = 32'h4000_0000;
    localparam logic [31:0] NS_EXT_B = 32'h8000_0000;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_STOP   = 2'd1,
        CMD_RETRIG = 2'd2,
        CMD_BAD    = 2'd3
    } t_cmd_code;

    typedef enum logic [2:0] {
        K_VICTIM   = 3'd0,
        K_STARTED  = 3'd1,
        K_RETRIG   = 3'd2,
        K_STOPPED  = 3'd3,
        K_IGNORED  = 3'd4,
        K_REJECTED = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        SCAN_ID    = 2'd0,
        SCAN_OLD   = 2'd1,
        SCAN_MULTI = 2'd2
    } t_scan_mode;

    typedef enum logic [1:0] {
        SRC_ECHO   = 2'd0,
        SRC_EX     = 2'd1,
        SRC_VICTIM = 2'd2
    } t_src;

    typedef struct packed {
        logic       load;
        logic       scan_go;
        t_scan_mode scan_mode;
        logic       set_stops;
        logic       add_vic;
        logic       set_mv;
        logic       vic_rd;
        logic       vi_inc;
        logic       emit;
        t_kind      kind;
        t_src       src;
        logic       last;
        logic       kill_ex;
        logic       kill_vic;
        logic       wr_new;
        logic       wr_retrig;
    } t_dp_cmd;

    typedef struct packed {
        logic invalid;
        logic is_stop;
        logic ent_multi;
        logic scan_done;
        logic ex_found;
        logic gen_ok;
        logic stops_zero;
        logic best_vld;
        logic need_multi;
        logic free_found;
        logic any_vic;
        logic more_vic;
        logic out_free;
    } t_dp_sts;

    function automatic logic [SLOT_W-1:0] slot_of(input logic [ENT_IW-1:0] e,
                                                  input logic [SUB_W-1:0]  s);
        return SLOT_W'(int'(e) * VOICES_PER_ENTITY + int'(s));
    endfunction

endpackage

FILE: rtl/core/note_voice_allocator_oldest_steal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// note_voice_allocator_oldest_steal
// Voice table with retrigger, per-entity and global multi oldest-voice steal.
// ----------------------------------------------------------------------------
// One note event is handled at a time; o_stall is high from the transfer until
// the last result of that event has been written to the output register. All
// per-slot words sit in memories with one read port, read one slot per cycle,
// so the time per event is set by the scans. An invalid event is rejected
// without a scan; a stop, retrigger or plain start makes one pass over the
// entity's 8 slots; each voice stolen from the entity adds another 8-slot pass
// plus the victim read and its result, and a global multi steal adds a pass
// over all 128 slots plus the victim read and its result. Any output stall
// adds to this.
module note_voice_allocator_oldest_steal
    import nva_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [3:0]  i_entity,
    input  logic [31:0] i_voice_id,
    input  logic [6:0]  i_note_number,
    input  logic [6:0]  i_note_velocity,
    input  logic [3:0]  i_midi_chan,
    input  logic [31:0] i_cause_id,
    input  logic [31:0] i_gen_tag,
    input  logic [3:0]  i_entity_voice_limit,
    input  logic        i_entity_is_multi,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_result_kind,
    output logic [3:0]  o_out_entity,
    output logic [31:0] o_out_voice_id,
    output logic [6:0]  o_out_note,
    output logic        o_out_external,
    output logic        o_last
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    nva_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    nva_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_sts                (sts),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_data           (i_cfg_data),
        .i_command            (i_command),
        .i_entity             (i_entity),
        .i_voice_id           (i_voice_id),
        .i_note_number        (i_note_number),
        .i_note_velocity      (i_note_velocity),
        .i_midi_chan          (i_midi_chan),
        .i_cause_id           (i_cause_id),
        .i_gen_tag            (i_gen_tag),
        .i_entity_voice_limit (i_entity_voice_limit),
        .i_entity_is_multi    (i_entity_is_multi),
        .i_stall              (i_stall),
        .o_valid              (o_valid),
        .o_result_kind        (o_result_kind),
        .o_out_entity         (o_out_entity),
        .o_out_voice_id       (o_out_voice_id),
        .o_out_note           (o_out_note),
        .o_out_external       (o_out_external),
        .o_last               (o_last)
    );

endmodule

FILE: rtl/core/nva_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nva_ctrl
// Sequencer for one note event: lookup, victim search, emission, commit.
// ----------------------------------------------------------------------------
module nva_ctrl
    import nva_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_SCAN_ID, S_DECIDE, S_OLD_NEXT, S_SCAN_OLD, S_ADDV,
        S_MCHK, S_SCAN_MUL, S_MADD, S_FREE, S_VRD, S_VEM, S_WRITE,
        S_REJ, S_IGN, S_STOP, S_RETRIG
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.invalid) begin
                    n_state = S_REJ;
                end else begin
                    o_cmd.scan_go   = 1'b1;
                    o_cmd.scan_mode = SCAN_ID;
                    n_state         = S_SCAN_ID;
                end
            end
            S_SCAN_ID: begin
                if (i_sts.scan_done) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                priority if (i_sts.is_stop) begin
                    n_state = (i_sts.ex_found && i_sts.gen_ok) ? S_STOP : S_IGN;
                end else if (i_sts.ex_found) begin
                    n_state = S_RETRIG;
                end else begin
                    o_cmd.set_stops = 1'b1;
                    n_state         = S_OLD_NEXT;
                end
            end
            S_OLD_NEXT: begin
                if (i_sts.stops_zero) begin
                    n_state = S_MCHK;
                end else begin
                    o_cmd.scan_go   = 1'b1;
                    o_cmd.scan_mode = SCAN_OLD;
                    n_state         = S_SCAN_OLD;
                end
            end
            S_SCAN_OLD: begin
                if (i_sts.scan_done) n_state = S_ADDV;
            end
            S_ADDV: begin
                o_cmd.add_vic = 1'b1;
                n_state       = S_OLD_NEXT;
            end
            S_MCHK: begin
                if (i_sts.ent_multi && i_sts.need_multi) begin
                    o_cmd.scan_go   = 1'b1;
                    o_cmd.scan_mode = SCAN_MULTI;
                    n_state         = S_SCAN_MUL;
                end else begin
                    n_state = S_FREE;
                end
            end
            S_SCAN_MUL: begin
                if (i_sts.scan_done) n_state = S_MADD;
            end
            S_MADD: begin
                if (i_sts.best_vld) begin
                    o_cmd.set_mv = 1'b1;
                    n_state      = S_FREE;
                end else begin
                    n_state = S_REJ;
                end
            end
            S_FREE: begin
                priority if (!i_sts.free_found) n_state = S_REJ;
                else if (i_sts.any_vic)         n_state = S_VRD;
                else                            n_state = S_WRITE;
            end
            S_VRD: begin
                o_cmd.vic_rd = 1'b1;
                n_state      = S_VEM;
            end
            S_VEM: begin
                if (i_sts.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.kind     = K_VICTIM;
                    o_cmd.src      = SRC_VICTIM;
                    o_cmd.kill_vic = 1'b1;
                    o_cmd.vi_inc   = 1'b1;
                    n_state        = i_sts.more_vic ? S_VRD : S_WRITE;
                end
            end
            S_WRITE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.kind   = K_STARTED;
                    o_cmd.src    = SRC_ECHO;
                    o_cmd.last   = 1'b1;
                    o_cmd.wr_new = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_REJ, S_IGN: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = (r_state == S_REJ) ? K_REJECTED : K_IGNORED;
                    o_cmd.src  = SRC_ECHO;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_STOP: begin
                if (i_sts.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.kind    = K_STOPPED;
                    o_cmd.src     = SRC_EX;
                    o_cmd.last    = 1'b1;
                    o_cmd.kill_ex = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_RETRIG: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.kind      = K_RETRIG;
                    o_cmd.src       = SRC_ECHO;
                    o_cmd.last      = 1'b1;
                    o_cmd.wr_retrig = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

FILE: rtl/core/nva_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nva_dp
// Slot memories, live/multi flags, scan unit, victim list and result register.
// ----------------------------------------------------------------------------
module nva_dp
    import nva_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic [1:0]  i_command,
    input  logic [3:0]  i_entity,
    input  logic [31:0] i_voice_id,
    input  logic [6:0]  i_note_number,
    input  logic [6:0]  i_note_velocity,
    input  logic [3:0]  i_midi_chan,
    input  logic [31:0] i_cause_id,
    input  logic [31:0] i_gen_tag,
    input  logic [3:0]  i_entity_voice_limit,
    input  logic        i_entity_is_multi,
    input  logic        i_stall,
    output logic        o_valid,
    output logic [2:0]  o_result_kind,
    output logic [3:0]  o_out_entity,
    output logic [31:0] o_out_voice_id,
    output logic [6:0]  o_out_note,
    output logic        o_out_external,
    output logic        o_last
);

    function automatic logic ext_of(input logic [31:0] c);
        return ((c & NS_MASK) == NS_EXT_A) || ((c & NS_MASK) == NS_EXT_B);
    endfunction

    // captured item
    logic [1:0]  r_cmd;
    logic [3:0]  r_ent;
    logic [31:0] r_id, r_cause, r_gen;
    logic [6:0]  r_note, r_vel;
    logic [3:0]  r_chan, r_lim;
    logic        r_ism;
    logic [7:0]  r_limit;

    // slot memories; {chan, velocity, note} packed in the info word
    logic [31:0] m_id    [SLOT_COUNT];
    logic [31:0] m_cause [SLOT_COUNT];
    logic [31:0] m_gen   [SLOT_COUNT];
    logic [31:0] m_age   [SLOT_COUNT];
    logic [17:0] m_info  [SLOT_COUNT];
    logic [31:0] q_id, q_cause, q_gen, q_age;
    logic [17:0] q_info;

    logic [SLOT_COUNT-1:0] r_alive, r_multi;
    logic [MLIVE_W-1:0]    r_mlive;
    logic [31:0]           r_age_cnt;

    // scan unit
    logic              r_scan_on;
    t_scan_mode        r_mode;
    logic [ENT_IW-1:0] r_sc_ent, r_rd_ent;
    logic [SUB_W-1:0]  r_sc_sub, r_rd_sub;
    logic              r_rd_vld, r_rd_last;
    logic              sc_last;

    logic             r_ex_found, r_ex_gen_ok, r_ex_ext;
    logic [SUB_W-1:0] r_ex_sub;
    logic [6:0]       r_ex_note;

    logic              r_best_vld;
    logic [31:0]       r_best_age;
    logic [ENT_IW-1:0] r_best_ent;
    logic [SUB_W-1:0]  r_best_sub;

    // victim list
    logic [SUB_W-1:0]             r_vic_sub [VOICES_PER_ENTITY];
    logic [VOICES_PER_ENTITY-1:0] r_vmask;
    logic [CNT_W-1:0]             r_nv, r_left;
    logic                         r_mv_vld;
    logic [ENT_IW-1:0]            r_mv_ent;
    logic [SUB_W-1:0]             r_mv_sub;
    logic [VIC_W-1:0]             r_vi;

    logic              r_out_vld;
    logic              out_free;
    logic [ENT_IW-1:0] cur_ent;
    logic [SLOT_W-1:0] rd_slot, ex_slot, vic_slot, new_slot, rd_addr, wr_addr;
    logic [ENT_IW-1:0] vic_ent;
    logic [SUB_W-1:0]  vic_sub, free_sub;
    logic              free_found, rd_en, wr_en, excluded, cand;
    logic [CNT_W-1:0]  live, lim_c, stops;
    logic [VIC_W-1:0]  nvt;

    assign cur_ent  = ENT_IW'(r_ent);
    assign rd_slot  = slot_of(r_rd_ent, r_rd_sub);
    assign ex_slot  = slot_of(cur_ent, r_ex_sub);
    assign new_slot = slot_of(cur_ent, free_sub);
    assign out_free = !r_out_vld || !i_stall;

    // victim selection: entity victims in order, then the multi victim
    assign nvt = VIC_W'(r_nv) + VIC_W'(r_mv_vld);
    always_comb begin
        if (r_vi < VIC_W'(r_nv)) begin
            vic_ent = cur_ent;
            vic_sub = r_vic_sub[r_vi[SUB_W-1:0]];
        end else begin
            vic_ent = r_mv_ent;
            vic_sub = r_mv_sub;
        end
    end
    assign vic_slot = slot_of(vic_ent, vic_sub);

    // live count, limit clamp, free slot
    always_comb begin
        live       = '0;
        free_found = 1'b0;
        free_sub   = '0;
        for (int i = 0; i < VOICES_PER_ENTITY; i++) begin
            if (r_alive[slot_of(cur_ent, SUB_W'(i))]) live = live + 1'b1;
            if (!free_found && (!r_alive[slot_of(cur_ent, SUB_W'(i))] || r_vmask[i]
                || (r_mv_vld && r_mv_ent == cur_ent && r_mv_sub == SUB_W'(i)))) begin
                free_found = 1'b1;
                free_sub   = SUB_W'(i);
            end
        end
        priority if (r_lim == 4'd0)                        lim_c = CNT_W'(1);
        else if (int'(r_lim) > VOICES_PER_ENTITY)          lim_c = CNT_W'(VOICES_PER_ENTITY);
        else                                               lim_c = CNT_W'(r_lim);
        stops = (live >= lim_c) ? CNT_W'(live - lim_c + 1'b1) : '0;
    end

    assign sc_last = (r_sc_sub == SUB_W'(VOICES_PER_ENTITY - 1))
                     && (r_mode != SCAN_MULTI || r_sc_ent == ENT_IW'(ENTITY_COUNT - 1));
    assign rd_en   = r_scan_on || i_cmd.vic_rd;
    assign rd_addr = r_scan_on ? slot_of(r_sc_ent, r_sc_sub) : vic_slot;
    assign wr_en   = i_cmd.wr_new || i_cmd.wr_retrig;
    assign wr_addr = i_cmd.wr_retrig ? ex_slot : new_slot;

    assign excluded = (r_rd_ent == cur_ent) && r_vmask[r_rd_sub];
    assign cand     = r_alive[rd_slot] && !excluded
                      && (r_mode != SCAN_MULTI || r_multi[rd_slot]);

    // memories
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            m_id[wr_addr]    <= r_id;
            m_cause[wr_addr] <= r_cause;
            m_gen[wr_addr]   <= r_gen;
            m_age[wr_addr]   <= r_age_cnt + 32'd1;
            m_info[wr_addr]  <= {r_chan, r_vel, r_note};
        end
        if (rd_en) begin
            q_id    <= m_id[rd_addr];
            q_cause <= m_cause[rd_addr];
            q_gen   <= m_gen[rd_addr];
            q_age   <= m_age[rd_addr];
            q_info  <= m_info[rd_addr];
        end
    end

    // item capture and search results
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_command;
            r_ent   <= i_entity;
            r_id    <= i_voice_id;
            r_note  <= i_note_number;
            r_vel   <= i_note_velocity;
            r_chan  <= i_midi_chan;
            r_cause <= i_cause_id;
            r_gen   <= i_gen_tag;
            r_lim   <= i_entity_voice_limit;
            r_ism   <= i_entity_is_multi;
        end
        if (r_rd_vld && r_mode == SCAN_ID && !r_ex_found && r_alive[rd_slot]
            && q_id == r_id) begin
            r_ex_sub    <= r_rd_sub;
            r_ex_gen_ok <= (q_gen == r_gen);
            r_ex_note   <= q_info[6:0];
            r_ex_ext    <= ext_of(q_cause);
        end
        if (r_rd_vld && r_mode != SCAN_ID && cand && (!r_best_vld || q_age < r_best_age)) begin
            r_best_age <= q_age;
            r_best_ent <= r_rd_ent;
            r_best_sub <= r_rd_sub;
        end
        if (i_cmd.add_vic) r_vic_sub[r_nv[SUB_W-1:0]] <= r_best_sub;
        if (i_cmd.set_mv) begin
            r_mv_ent <= r_best_ent;
            r_mv_sub <= r_best_sub;
        end
    end

    // control state of the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit    <= MULTI_LIMIT_RESET;
            r_alive    <= '0;
            r_multi    <= '0;
            r_mlive    <= '0;
            r_age_cnt  <= '0;
            r_scan_on  <= 1'b0;
            r_mode     <= SCAN_ID;
            r_sc_ent   <= '0;
            r_sc_sub   <= '0;
            r_rd_vld   <= 1'b0;
            r_rd_last  <= 1'b0;
            r_rd_ent   <= '0;
            r_rd_sub   <= '0;
            r_ex_found <= 1'b0;
            r_best_vld <= 1'b0;
            r_vmask    <= '0;
            r_nv       <= '0;
            r_left     <= '0;
            r_mv_vld   <= 1'b0;
            r_vi       <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) r_limit <= i_cfg_data;

            if (i_cmd.load) begin
                r_vmask  <= '0;
                r_nv     <= '0;
                r_mv_vld <= 1'b0;
                r_vi     <= '0;
            end

            // scan issue, one slot per cycle
            if (i_cmd.scan_go) begin
                r_scan_on  <= 1'b1;
                r_mode     <= i_cmd.scan_mode;
                r_sc_ent   <= (i_cmd.scan_mode == SCAN_MULTI) ? '0 : cur_ent;
                r_sc_sub   <= '0;
                r_best_vld <= 1'b0;
                if (i_cmd.scan_mode == SCAN_ID) r_ex_found <= 1'b0;
            end else if (r_scan_on) begin
                if (sc_last) r_scan_on <= 1'b0;
                if (r_sc_sub == SUB_W'(VOICES_PER_ENTITY - 1)) begin
                    r_sc_sub <= '0;
                    r_sc_ent <= r_sc_ent + 1'b1;
                end else begin
                    r_sc_sub <= r_sc_sub + 1'b1;
                end
            end
            r_rd_vld  <= r_scan_on;
            r_rd_last <= r_scan_on && sc_last;
            r_rd_ent  <= r_sc_ent;
            r_rd_sub  <= r_sc_sub;

            if (r_rd_vld && r_mode == SCAN_ID && r_alive[rd_slot] && q_id == r_id)
                r_ex_found <= 1'b1;
            if (r_rd_vld && r_mode != SCAN_ID && cand) r_best_vld <= 1'b1;

            if (i_cmd.set_stops) r_left <= stops;
            if (i_cmd.add_vic) begin
                r_vmask[r_best_sub] <= 1'b1;
                r_nv                <= r_nv + 1'b1;
                r_left              <= r_left - 1'b1;
            end
            if (i_cmd.set_mv) r_mv_vld <= 1'b1;
            if (i_cmd.vi_inc) r_vi <= r_vi + 1'b1;

            // voice flags and multi total
            if (i_cmd.kill_ex) begin
                r_alive[ex_slot] <= 1'b0;
                if (r_multi[ex_slot]) r_mlive <= r_mlive - 1'b1;
            end
            if (i_cmd.kill_vic) begin
                r_alive[vic_slot] <= 1'b0;
                if (r_multi[vic_slot]) r_mlive <= r_mlive - 1'b1;
            end
            if (i_cmd.wr_new) begin
                r_alive[new_slot] <= 1'b1;
                r_multi[new_slot] <= r_ism;
                if (r_ism) r_mlive <= r_mlive + 1'b1;
            end
            if (wr_en) r_age_cnt <= r_age_cnt + 32'd1;

            if (i_cmd.emit)                 r_out_vld <= 1'b1;
            else if (r_out_vld && !i_stall) r_out_vld <= 1'b0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_result_kind <= i_cmd.kind;
            o_last        <= i_cmd.last;
            unique case (i_cmd.src)
                SRC_VICTIM: begin
                    o_out_entity   <= 4'(vic_ent);
                    o_out_voice_id <= q_id;
                    o_out_note     <= q_info[6:0];
                    o_out_external <= ext_of(q_cause);
                end
                SRC_EX: begin
                    o_out_entity   <= r_ent;
                    o_out_voice_id <= r_id;
                    o_out_note     <= r_ex_note;
                    o_out_external <= r_ex_ext;
                end
                default: begin
                    o_out_entity   <= r_ent;
                    o_out_voice_id <= r_id;
                    o_out_note     <= r_note;
                    o_out_external <= ext_of(r_cause);
                end
            endcase
        end
    end

    assign o_valid = r_out_vld;

    assign o_sts.invalid    = (int'(r_ent) >= ENTITY_COUNT) || (r_cmd == CMD_BAD)
                              || (r_id == 32'd0);
    assign o_sts.is_stop    = (r_cmd == CMD_STOP);
    assign o_sts.ent_multi  = r_ism;
    assign o_sts.scan_done  = r_rd_vld && r_rd_last;
    assign o_sts.ex_found   = r_ex_found;
    assign o_sts.gen_ok     = r_ex_gen_ok;
    assign o_sts.stops_zero = (r_left == '0);
    assign o_sts.best_vld   = r_best_vld;
    assign o_sts.need_multi = (CMP_W'(r_mlive) + CMP_W'(1)) > (CMP_W'(r_limit) + CMP_W'(r_nv));
    assign o_sts.free_found = free_found;
    assign o_sts.any_vic    = (nvt != '0);
    assign o_sts.more_vic   = ((r_vi + 1'b1) < nvt);
    assign o_sts.out_free   = out_free;

    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> out_free) else $error("result written over a pending transfer");
    a_new_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_new |-> free_found) else $error("new voice without a free slot");
    a_nv_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_nv) <= VOICES_PER_ENTITY) else $error("victim count overflow");
    a_mlive_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_mlive) <= SLOT_COUNT) else $error("multi total overflow");

endmodule
